// ===== rtl/ocs_pkg.sv =====
// Shared types, register codes, matrix coefficients and helper functions of the colour smoother.
`timescale 1ns / 1ps
`default_nettype none
package ocs_pkg;

    localparam int ColorWidth = 16;
    localparam int InShift    = 24 - ColorWidth;

    // Configuration register indexes.
    localparam logic [1:0] REG_FACTOR = 2'd0;
    localparam logic [1:0] REG_MODE   = 2'd1;

    // Blend modes.
    localparam logic [1:0] MODE_LINEAR = 2'd0;
    localparam logic [1:0] MODE_LOG    = 2'd1;
    localparam logic [1:0] MODE_OKLAB  = 2'd2;
    localparam logic [1:0] MODE_SNAP   = 2'd3;

    // Lane operations.
    localparam logic [2:0] OP_MAC  = 3'd0;
    localparam logic [2:0] OP_CBRT = 3'd1;
    localparam logic [2:0] OP_CUBE = 3'd2;
    localparam logic [2:0] OP_LOG  = 3'd3;
    localparam logic [2:0] OP_EXP  = 3'd4;

    // Matrix selectors.
    localparam logic [1:0] MAT_RGB2LMS  = 2'd0;
    localparam logic [1:0] MAT_CBRT2LAB = 2'd1;
    localparam logic [1:0] MAT_LAB2CBRT = 2'd2;
    localparam logic [1:0] MAT_LMS2RGB  = 2'd3;

    localparam logic signed [24:0] K_RGB2LMS [0:2][0:2] = '{
        '{25'sd432246, 25'sd562385, 25'sd53945},
        '{25'sd222197, 25'sd713765, 25'sd112614},
        '{25'sd92592,  25'sd295404, 25'sd660581}};
    localparam logic signed [24:0] K_CBRT2LAB [0:2][0:2] = '{
        '{25'sd220677,  25'sd832169,   -25'sd4270},
        '{25'sd2074082, -25'sd2546563, 25'sd472482},
        '{25'sd27162,   25'sd820796,   -25'sd847958}};
    localparam logic signed [24:0] K_LAB2CBRT [0:2][0:2] = '{
        '{25'sd1048576, 25'sd415590,  25'sd226287},
        '{25'sd1048576, -25'sd110689, -25'sd66956},
        '{25'sd1048576, -25'sd93831,  -25'sd1354221}};
    localparam logic signed [24:0] K_LMS2RGB [0:2][0:2] = '{
        '{25'sd4274773,  -25'sd3468387, 25'sd242190},
        '{-25'sd1330054, 25'sd2736529,  -25'sd357899},
        '{-25'sd4400,    -25'sd737588,  25'sd1790564}};

    typedef struct packed {
        logic [15:0] target_red;
        logic [15:0] target_green;
        logic [15:0] target_blue;
        logic [15:0] delta_time;
    } t_in_word;

    typedef struct packed {
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
    } t_out_word;

    typedef struct packed {
        logic              start;
        logic [2:0]        op;
        logic [2:0][24:0]  a;
        logic [2:0][27:0]  b;
        logic [4:0]        sh;
    } t_lane_cmd;

    typedef struct packed {
        logic               done;
        logic signed [39:0] res;
    } t_lane_rsp;

    function automatic logic signed [24:0] mat_coef(input logic [1:0] m,
                                                    input logic [1:0] r,
                                                    input logic [1:0] c);
        logic signed [24:0] v;
        unique case (m)
            MAT_RGB2LMS:  v = K_RGB2LMS[r][c];
            MAT_CBRT2LAB: v = K_CBRT2LAB[r][c];
            MAT_LAB2CBRT: v = K_LAB2CBRT[r][c];
            default:      v = K_LMS2RGB[r][c];
        endcase
        return v;
    endfunction

    // Arithmetic right shift that rounds half away from zero.
    function automatic logic signed [63:0] rshift(input logic signed [63:0] v,
                                                  input logic [4:0] s);
        logic [63:0] half;
        logic [63:0] mag;
        half = (64'd1 << s) >> 1;
        mag  = v[63] ? (64'd0 - $unsigned(v)) : $unsigned(v);
        mag  = (mag + half) >> s;
        return v[63] ? $signed(64'd0 - mag) : $signed(mag);
    endfunction

    function automatic logic [15:0] sat16(input logic signed [63:0] v);
        logic [15:0] r;
        if (v[63]) begin
            r = 16'd0;
        end else if (v > 64'sd65535) begin
            r = 16'hFFFF;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/ocs_lane.sv =====
// One channel lane: multiply-accumulate, cube root, cube, base-2 log and its inverse search.
`timescale 1ns / 1ps
`default_nettype none
module ocs_lane (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  ocs_pkg::t_lane_cmd i_cmd,
    output ocs_pkg::t_lane_rsp o_rsp
);
    import ocs_pkg::*;

    localparam logic [3:0] L_IDLE = 4'd0;
    localparam logic [3:0] L_MAC  = 4'd1;
    localparam logic [3:0] L_MACR = 4'd2;
    localparam logic [3:0] L_CBSQ = 4'd3;
    localparam logic [3:0] L_CBCU = 4'd4;
    localparam logic [3:0] L_CUSQ = 4'd5;
    localparam logic [3:0] L_CUCU = 4'd6;
    localparam logic [3:0] L_LGIN = 4'd7;
    localparam logic [3:0] L_LGSQ = 4'd8;
    localparam logic [3:0] L_LGND = 4'd9;

    logic [3:0]         r_st;
    logic [2:0]         r_op;
    logic [2:0][24:0]   r_a;
    logic [2:0][27:0]   r_b;
    logic [4:0]         r_sh;
    logic [1:0]         r_k;
    logic signed [63:0] r_acc;
    logic signed [39:0] r_res;
    logic               r_done;
    logic [18:0]        r_root;
    logic [4:0]         r_bit;
    logic [39:0]        r_sq;
    logic [30:0]        r_m;
    logic [15:0]        r_frac;
    logic [3:0]         r_p;
    logic [3:0]         r_cnt;
    logic [15:0]        r_x;
    logic [15:0]        r_y;
    logic [3:0]         r_ebit;

    logic signed [52:0] w_prod;
    logic [18:0]        w_c;
    logic [37:0]        w_csq;
    logic [56:0]        w_ccu;
    logic signed [19:0] w_pv;
    logic signed [39:0] w_psq;
    logic signed [60:0] w_pcu;
    logic [15:0]        w_x1;
    logic [3:0]         w_msb;
    logic [30:0]        w_m0;
    logic [61:0]        w_lsq;
    logic [31:0]        w_m2;
    logic [19:0]        w_log;
    logic [15:0]        w_ynew;
    logic signed [63:0] w_cube_rnd;

    assign w_prod = $signed(r_a[r_k]) * $signed(r_b[r_k]);
    assign w_c    = r_root | (19'd1 << r_bit);
    assign w_csq  = w_c * w_c;
    assign w_ccu  = r_sq[37:0] * w_c;
    assign w_pv   = $signed(r_b[0][19:0]);
    assign w_psq  = w_pv * w_pv;
    assign w_pcu  = $signed({1'b0, r_sq}) * w_pv;
    assign w_cube_rnd = rshift({{3{w_pcu[60]}}, w_pcu}, 5'd28);
    assign w_x1   = (r_x == 16'd0) ? 16'd1 : r_x;
    assign w_lsq  = r_m * r_m;
    assign w_m2   = w_lsq[61:30];
    assign w_log  = {r_p, r_frac};
    assign w_ynew = (w_log <= r_b[0][19:0]) ? r_x : r_y;

    always_comb begin
        w_msb = 4'd0;
        for (int j = 0; j < 16; j++) begin
            if (w_x1[j]) w_msb = 4'(j);
        end
    end
    assign w_m0 = 31'({15'd0, w_x1} << (5'd30 - {1'b0, w_msb}));

    always_ff @(posedge i_clk) begin
        r_done <= 1'b0;
        if (!i_rst_n) begin
            r_st <= L_IDLE;
        end else begin
            unique case (r_st)
                L_IDLE: begin
                    if (i_cmd.start) begin
                        r_op   <= i_cmd.op;
                        r_a    <= i_cmd.a;
                        r_b    <= i_cmd.b;
                        r_sh   <= i_cmd.sh;
                        r_k    <= 2'd0;
                        r_acc  <= 64'sd0;
                        r_root <= 19'd0;
                        r_bit  <= 5'd18;
                        unique case (i_cmd.op)
                            OP_MAC:  r_st <= L_MAC;
                            OP_CBRT: begin
                                if ($signed(i_cmd.b[0]) <= 28'sd0) begin
                                    r_res  <= 40'sd0;
                                    r_done <= 1'b1;
                                end else begin
                                    r_st <= L_CBSQ;
                                end
                            end
                            OP_CUBE: r_st <= L_CUSQ;
                            OP_LOG: begin
                                r_x  <= i_cmd.b[0][15:0];
                                r_st <= L_LGIN;
                            end
                            OP_EXP: begin
                                r_y    <= 16'd0;
                                r_ebit <= 4'd15;
                                r_x    <= 16'h8000;
                                r_st   <= L_LGIN;
                            end
                            default: r_st <= L_IDLE;
                        endcase
                    end
                end
                L_MAC: begin
                    r_acc <= r_acc + {{11{w_prod[52]}}, w_prod};
                    r_k   <= r_k + 2'd1;
                    if (r_k == 2'd2) r_st <= L_MACR;
                end
                L_MACR: begin
                    r_res  <= 40'(rshift(r_acc, r_sh));
                    r_done <= 1'b1;
                    r_st   <= L_IDLE;
                end
                L_CBSQ: begin
                    r_sq <= {2'b00, w_csq};
                    r_st <= L_CBCU;
                end
                L_CBCU: begin
                    if (w_ccu <= {1'b0, r_b[0], 28'd0}) r_root <= w_c;
                    if (r_bit == 5'd0) begin
                        r_res  <= (w_ccu <= {1'b0, r_b[0], 28'd0}) ? 40'($signed({1'b0, w_c}))
                                                                  : 40'($signed({1'b0, r_root}));
                        r_done <= 1'b1;
                        r_st   <= L_IDLE;
                    end else begin
                        r_bit <= r_bit - 5'd1;
                        r_st  <= L_CBSQ;
                    end
                end
                L_CUSQ: begin
                    r_sq <= $unsigned(w_psq);
                    r_st <= L_CUCU;
                end
                L_CUCU: begin
                    r_res  <= w_cube_rnd[39:0];
                    r_done <= 1'b1;
                    r_st   <= L_IDLE;
                end
                L_LGIN: begin
                    r_p    <= w_msb;
                    r_m    <= w_m0;
                    r_frac <= 16'd0;
                    r_cnt  <= 4'd0;
                    r_st   <= L_LGSQ;
                end
                L_LGSQ: begin
                    // Squaring doubles the log; an overflow past two yields the next bit.
                    r_frac <= {r_frac[14:0], w_m2[31]};
                    r_m    <= w_m2[31] ? w_m2[31:1] : w_m2[30:0];
                    r_cnt  <= r_cnt + 4'd1;
                    if (r_cnt == 4'd15) r_st <= L_LGND;
                end
                L_LGND: begin
                    if (r_op == OP_LOG) begin
                        r_res  <= 40'($signed({1'b0, w_log}));
                        r_done <= 1'b1;
                        r_st   <= L_IDLE;
                    end else if (r_ebit == 4'd0) begin
                        r_res  <= 40'($signed({1'b0, w_ynew}));
                        r_done <= 1'b1;
                        r_st   <= L_IDLE;
                    end else begin
                        r_y    <= w_ynew;
                        r_x    <= w_ynew | (16'd1 << (r_ebit - 4'd1));
                        r_ebit <= r_ebit - 4'd1;
                        r_st   <= L_LGIN;
                    end
                end
                default: r_st <= L_IDLE;
            endcase
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.res  = r_res;

endmodule
`default_nettype wire

// ===== rtl/oklab_color_smoother.sv =====
// Top level: register port, weight calculation, step sequencer over three lanes and result merge.
// The first word, or any word in snap mode, is passed straight to the result; linear mode runs
// one blend, Oklab mode two cube root passes and logarithmic mode an inverse log search.
// One word is in work at a time; the next is taken in the cycle after the result is loaded,
// even while it waits in the output register. Reset (synchronous, active low) clears the held
// colour, flag and handshakes; the factor is 1.0 and the mode Oklab.
`timescale 1ns / 1ps
`default_nettype none
module oklab_color_smoother (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_in_valid,
    output logic               o_in_ready,
    input  ocs_pkg::t_in_word  i_in,
    output logic               o_out_valid,
    input  wire                i_out_ready,
    output ocs_pkg::t_out_word o_out,
    input  wire                i_cfg_valid,
    output logic               o_cfg_ready,
    input  wire [1:0]          i_cfg_index,
    input  wire [15:0]         i_cfg_data
);
    import ocs_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_LMS  = 4'd1;
    localparam logic [3:0] S_CBRT = 4'd2;
    localparam logic [3:0] S_LAB  = 4'd3;
    localparam logic [3:0] S_MIX  = 4'd4;
    localparam logic [3:0] S_PRE  = 4'd5;
    localparam logic [3:0] S_CUBE = 4'd6;
    localparam logic [3:0] S_RGB  = 4'd7;
    localparam logic [3:0] S_LIN  = 4'd8;
    localparam logic [3:0] S_LGA  = 4'd9;
    localparam logic [3:0] S_LGB  = 4'd10;
    localparam logic [3:0] S_LGM  = 4'd11;
    localparam logic [3:0] S_LGE  = 4'd12;
    localparam logic [3:0] S_FIN  = 4'd13;

    logic [3:0]         r_state;
    logic               r_issued;
    logic               r_side;
    logic [15:0]        r_factor;
    logic [1:0]         r_mode;
    logic [16:0]        r_t;
    logic               r_holds;
    logic [15:0]        r_tgt [3];
    logic [15:0]        r_cur [3];
    logic [15:0]        r_res [3];
    logic signed [21:0] r_lc [3];
    logic signed [21:0] r_lt [3];
    logic signed [39:0] r_vec [3];
    logic               r_ovalid;
    t_out_word          r_out;

    t_lane_cmd          w_cmd [3];
    t_lane_rsp          w_rsp [3];
    logic               w_accept;
    logic               w_start;
    logic               w_done;
    logic [31:0]        w_tprod;
    logic [16:0]        w_t;
    logic [15:0]        w_in_col [3];

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_tprod     = i_in.delta_time * r_factor;
    assign w_t         = (w_tprod[31:4] > 28'h0010000) ? 17'h10000 : w_tprod[20:4];
    assign w_start     = (r_state != S_IDLE) && (r_state != S_FIN) && !r_issued;
    assign w_done      = w_rsp[0].done;
    assign w_in_col[0] = i_in.target_red;
    assign w_in_col[1] = i_in.target_green;
    assign w_in_col[2] = i_in.target_blue;

    always_comb begin
        logic [15:0] col;
        col = 16'd0;
        for (int i = 0; i < 3; i++) begin
            w_cmd[i]       = '0;
            w_cmd[i].start = w_start;
            case (r_state)
                S_LMS: begin
                    w_cmd[i].op = OP_MAC;
                    w_cmd[i].sh = 5'd20;
                    for (int k = 0; k < 3; k++) begin
                        col = r_side ? r_tgt[k] : r_cur[k];
                        if (col == 16'd0) col = 16'd1;
                        w_cmd[i].a[k] = mat_coef(MAT_RGB2LMS, 2'(i), 2'(k));
                        w_cmd[i].b[k] = 28'(col) << InShift;
                    end
                end
                S_LAB, S_PRE, S_RGB: begin
                    w_cmd[i].op = OP_MAC;
                    w_cmd[i].sh = 5'd20;
                    for (int k = 0; k < 3; k++) begin
                        w_cmd[i].a[k] = mat_coef((r_state == S_LAB) ? MAT_CBRT2LAB :
                                                 (r_state == S_PRE) ? MAT_LAB2CBRT :
                                                 MAT_LMS2RGB, 2'(i), 2'(k));
                        w_cmd[i].b[k] = r_vec[k][27:0];
                    end
                end
                S_CBRT: begin
                    w_cmd[i].op   = OP_CBRT;
                    w_cmd[i].b[0] = r_vec[i][27:0];
                end
                S_CUBE: begin
                    w_cmd[i].op   = OP_CUBE;
                    w_cmd[i].b[0] = r_vec[i][27:0];
                end
                S_MIX, S_LGM, S_LIN: begin
                    w_cmd[i].op   = OP_MAC;
                    w_cmd[i].sh   = 5'd16;
                    w_cmd[i].a[0] = 25'(17'h10000 - r_t);
                    w_cmd[i].a[1] = 25'(r_t);
                    if (r_state == S_LIN) begin
                        w_cmd[i].b[0] = 28'(r_cur[i]);
                        w_cmd[i].b[1] = 28'(r_tgt[i]);
                    end else begin
                        w_cmd[i].b[0] = 28'(r_lc[i]);
                        w_cmd[i].b[1] = 28'(r_lt[i]);
                    end
                end
                S_LGA: begin
                    w_cmd[i].op   = OP_LOG;
                    w_cmd[i].b[0] = 28'(r_cur[i]);
                end
                S_LGB: begin
                    w_cmd[i].op   = OP_LOG;
                    w_cmd[i].b[0] = 28'(r_tgt[i]);
                end
                S_LGE: begin
                    w_cmd[i].op   = OP_EXP;
                    w_cmd[i].b[0] = r_vec[i][27:0];
                end
                default: w_cmd[i].start = 1'b0;
            endcase
        end
    end

    for (genvar g = 0; g < 3; g++) begin : g_lane
        ocs_lane u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (w_cmd[g]),
            .o_rsp   (w_rsp[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_issued <= 1'b0;
            r_ovalid <= 1'b0;
            r_holds  <= 1'b0;
            r_factor <= 16'd256;
            r_mode   <= MODE_OKLAB;
            for (int i = 0; i < 3; i++) r_cur[i] <= 16'd0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    REG_FACTOR: r_factor <= i_cfg_data;
                    REG_MODE:   r_mode   <= i_cfg_data[1:0];
                    default:    ;
                endcase
            end
            if (r_ovalid && i_out_ready) r_ovalid <= 1'b0;

            if (r_state != S_IDLE && r_state != S_FIN) begin
                if (!r_issued) r_issued <= 1'b1;
                else if (w_done) r_issued <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_t    <= w_t;
                        r_side <= 1'b0;
                        for (int i = 0; i < 3; i++) begin
                            r_tgt[i] <= w_in_col[i];
                            r_res[i] <= w_in_col[i];
                        end
                        if (!r_holds || r_mode == MODE_SNAP) begin
                            r_state <= S_FIN;
                        end else begin
                            unique case (r_mode)
                                MODE_LINEAR: r_state <= S_LIN;
                                MODE_LOG:    r_state <= S_LGA;
                                default:     r_state <= S_LMS;
                            endcase
                        end
                    end
                end
                S_FIN: begin
                    if (!r_ovalid || i_out_ready) begin
                        r_out    <= '{red: r_res[0], green: r_res[1], blue: r_res[2]};
                        r_ovalid <= 1'b1;
                        r_holds  <= 1'b1;
                        for (int i = 0; i < 3; i++) r_cur[i] <= r_res[i];
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    if (r_issued && w_done) begin
                        for (int i = 0; i < 3; i++) begin
                            case (r_state)
                                S_LAB, S_LGA, S_LGB: begin
                                    if ((r_state == S_LAB && !r_side) || r_state == S_LGA)
                                        r_lc[i] <= w_rsp[i].res[21:0];
                                    else
                                        r_lt[i] <= w_rsp[i].res[21:0];
                                end
                                S_RGB:
                                    r_res[i] <= sat16(rshift(64'(w_rsp[i].res), 5'(InShift)));
                                S_LIN, S_LGE:
                                    r_res[i] <= w_rsp[i].res[15:0];
                                default:
                                    r_vec[i] <= w_rsp[i].res;
                            endcase
                        end
                        case (r_state)
                            S_LMS:  r_state <= S_CBRT;
                            S_CBRT: r_state <= S_LAB;
                            S_LAB: begin
                                r_side  <= 1'b1;
                                r_state <= r_side ? S_MIX : S_LMS;
                            end
                            S_MIX:  r_state <= S_PRE;
                            S_PRE:  r_state <= S_CUBE;
                            S_CUBE: r_state <= S_RGB;
                            S_LGA:  r_state <= S_LGB;
                            S_LGB:  r_state <= S_LGM;
                            S_LGM:  r_state <= S_LGE;
                            default: r_state <= S_FIN;
                        endcase
                    end
                end
            endcase
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out       = r_out;

    // The lanes run the same operation in lock step, so they finish together.
    a_lanes_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_rsp[0].done == w_rsp[1].done) && (w_rsp[1].done == w_rsp[2].done))
        else $error("lanes finished out of step");

    a_holds_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_holds |=> r_holds)
        else $error("held flag dropped");

    a_single_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !o_in_ready)
        else $error("second word taken while one is in work");

    a_weight_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_t <= 17'h10000))
        else $error("blend weight above one");

    a_done_when_issued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |-> r_issued)
        else $error("lane result without a command");

endmodule
`default_nettype wire

// ===== bench/tb_top.sv =====
// Self-checking bench for the colour smoother: table-driven directed words, random phases, own predictor.
`timescale 1ns / 1ps
module tb_top;
    import ocs_pkg::*;

    localparam logic [1:0] REG_SPARE = 2'd3;
    localparam int         SETTLE = 400;
    localparam int         STALL_LIMIT = 4000;

    typedef longint trio_t [3];

    typedef struct {
        logic [1:0]  mode;
        logic [15:0] factor;
        logic [15:0] r, g, b, dt;
        bit          typed;
        logic [15:0] er, eg, eb;
    } row_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    t_in_word    i_in = '0;
    logic        i_out_ready = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic [1:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;
    logic        o_in_ready, o_out_valid, o_cfg_ready;
    t_out_word   o_out;

    // Bench mirror of the block's registers and held colour.
    logic [15:0] cfg_factor = 16'd256;
    logic [1:0]  cfg_mode = MODE_OKLAB;
    logic [15:0] held [3] = '{16'd0, 16'd0, 16'd0};
    bit          held_ok = 1'b0;

    t_out_word   colour_queue [$];
    bit          typed_on = 1'b0;
    t_out_word   typed_word = '0;
    int          errors = 0;
    int          words_in = 0;
    int          words_out = 0;
    int          idle_cycles = 0;
    bit          no_gaps = 1'b0;
    bit          hold_req = 1'b0;
    logic [1:0]  drive_mode = MODE_OKLAB;
    logic [15:0] drive_factor = 16'd256;

    oklab_color_smoother uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in(i_in),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out(o_out),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic longint rnd_shift(input longint v, input int s);
        longint half;
        half = longint'(1) << (s - 1);
        if (v >= 0) return (v + half) >>> s;
        return -((-v + half) >>> s);
    endfunction

    // Base-2 logarithm as Q8.16, fraction by repeated squaring of the mantissa.
    function automatic int unsigned log2_fix(input int unsigned x);
        int unsigned     lead, frac;
        longint unsigned m;
        lead = 0;
        frac = 0;
        if (x == 0) x = 1;
        for (int i = 0; i < 32; i++) if (x[i]) lead = i;
        m = longint'(x) << (30 - lead);
        for (int i = 0; i < 16; i++) begin
            m = (m * m) >> 30;
            frac = frac << 1;
            if (m >= (64'd1 << 31)) begin
                frac = frac | 1;
                m = m >> 1;
            end
        end
        return (lead << 16) | frac;
    endfunction

    function automatic logic [15:0] blend_log(input logic [15:0] a, input logic [15:0] b,
                                              input longint t);
        longint unsigned mixed;
        logic [15:0]     y, c;
        mixed = (longint'(log2_fix(a)) * (65536 - t) + longint'(log2_fix(b)) * t + 32768) >> 16;
        y = '0;
        for (int i = 15; i >= 0; i--) begin
            c = y;
            c[i] = 1'b1;
            if (longint'(log2_fix(c)) <= mixed) y = c;
        end
        return y;
    endfunction

    function automatic longint cube_root_fix(input longint v);
        longint unsigned n, r, c;
        if (v <= 0) return 0;
        n = longint'(v) << 28;
        r = 0;
        for (int i = 18; i >= 0; i--) begin
            c = r | (64'd1 << i);
            if (c * c * c <= n) r = c;
        end
        return longint'(r);
    endfunction

    function automatic trio_t colour_to_lab(input logic [15:0] c [3]);
        trio_t  lin, root, lab;
        longint s;
        for (int i = 0; i < 3; i++) lin[i] = longint'(c[i] == 0 ? 16'd1 : c[i]) << 8;
        for (int i = 0; i < 3; i++) begin
            s = 0;
            for (int k = 0; k < 3; k++) s += longint'(K_RGB2LMS[i][k]) * lin[k];
            root[i] = cube_root_fix(rnd_shift(s, 20));
        end
        for (int i = 0; i < 3; i++) begin
            s = 0;
            for (int k = 0; k < 3; k++) s += longint'(K_CBRT2LAB[i][k]) * root[k];
            lab[i] = rnd_shift(s, 20);
        end
        return lab;
    endfunction

    // Mixes the held colour toward the word's target and updates the mirror.
    function automatic t_out_word smooth_colour(input t_in_word w);
        logic [15:0]     tgt [3];
        logic [15:0]     res [3];
        longint unsigned prod;
        longint          t, s, p;
        trio_t           lc, lt, lm, lms;
        tgt = '{w.target_red, w.target_green, w.target_blue};
        prod = (longint'(w.delta_time) * cfg_factor) >> 4;
        t = (prod > 65536) ? 65536 : longint'(prod);
        if (!held_ok || cfg_mode == MODE_SNAP) begin
            res = tgt;
        end else if (cfg_mode == MODE_LINEAR) begin
            for (int i = 0; i < 3; i++)
                res[i] = 16'((longint'(held[i]) * (65536 - t) + longint'(tgt[i]) * t + 32768)
                             >> 16);
        end else if (cfg_mode == MODE_LOG) begin
            for (int i = 0; i < 3; i++) res[i] = blend_log(held[i], tgt[i], t);
        end else begin
            lc = colour_to_lab(held);
            lt = colour_to_lab(tgt);
            for (int i = 0; i < 3; i++) lm[i] = rnd_shift(lc[i] * (65536 - t) + lt[i] * t, 16);
            for (int i = 0; i < 3; i++) begin
                s = 0;
                for (int k = 0; k < 3; k++) s += longint'(K_LAB2CBRT[i][k]) * lm[k];
                p = rnd_shift(s, 20);
                lms[i] = rnd_shift(p * p * p, 28);
            end
            for (int i = 0; i < 3; i++) begin
                s = 0;
                for (int k = 0; k < 3; k++) s += longint'(K_LMS2RGB[i][k]) * lms[k];
                s = rnd_shift(rnd_shift(s, 20), 8);
                if (s < 0) s = 0;
                if (s > 65535) s = 65535;
                res[i] = 16'(s);
            end
        end
        held = res;
        held_ok = 1'b1;
        return '{red: res[0], green: res[1], blue: res[2]};
    endfunction

    task automatic report(input string what, input logic [15:0] want, input logic [15:0] got);
        $display("%0t ns: %s expected %h, got %h", $time, what, want, got);
        errors++;
    endtask

    // Scoreboard: mirrors register writes, predicts on each input word, checks each result.
    always @(posedge i_clk) begin
        t_out_word want;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == REG_FACTOR) cfg_factor = i_cfg_data;
                else if (i_cfg_index == REG_MODE) cfg_mode = i_cfg_data[1:0];
            end
            if (o_out_valid && i_out_ready) begin
                words_out++;
                if (colour_queue.size() == 0) begin
                    $display("%0t ns: result word with nothing outstanding", $time);
                    errors++;
                end else begin
                    want = colour_queue.pop_front();
                    if (o_out.red !== want.red) report("red", want.red, o_out.red);
                    if (o_out.green !== want.green) report("green", want.green, o_out.green);
                    if (o_out.blue !== want.blue) report("blue", want.blue, o_out.blue);
                end
            end
            if (i_in_valid && o_in_ready) begin
                words_in++;
                want = smooth_colour(i_in);
                if (typed_on) want = typed_word;
                colour_queue = {colour_queue, want};
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("oklab_color_smoother: mismatch");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Result side: random back-pressure, plus one long hold-off on request.
    initial begin
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                i_out_ready <= 1'b0;
                repeat (300) @(posedge i_clk);
            end else begin
                i_out_ready <= no_gaps || ($urandom_range(99) >= 37);
                @(posedge i_clk);
            end
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    // Drops valid, waits for the block to drain, then loads both registers.
    task automatic reconfigure(input logic [1:0] mode, input logic [15:0] factor);
        i_in_valid <= 1'b0;
        while (colour_queue.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        write_reg(REG_MODE, 16'(mode));
        write_reg(REG_FACTOR, factor);
        i_cfg_valid <= 1'b0;
        drive_mode = mode;
        drive_factor = factor;
    endtask

    task automatic send_word(input t_in_word w, input bit typed, input t_out_word want);
        int gap;
        gap = 0;
        if (!no_gaps) while ($urandom_range(99) < 37) gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= w;
        typed_on   <= typed;
        typed_word <= want;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    function automatic logic [15:0] pick_colour();
        case ($urandom_range(9))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2:       return 16'($urandom_range(15));
            3, 4:    return 16'($urandom_range(16'h1000));
            default: return 16'($urandom);
        endcase
    endfunction

    row_t steps [15] = '{
        '{MODE_OKLAB, 16'd256, 16'h1234, 16'h0000, 16'hFFFF, 16'h0100, 1,
          16'h1234, 16'h0000, 16'hFFFF},
        '{MODE_OKLAB, 16'd256, 16'h0000, 16'h0000, 16'h0000, 16'h0800, 0, 0, 0, 0},
        '{MODE_OKLAB, 16'd256, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 0, 0, 0},
        '{MODE_OKLAB, 16'd256, 16'h8000, 16'h0100, 16'h4000, 16'h0000, 0, 0, 0, 0},
        '{MODE_LINEAR, 16'd256, 16'hABCD, 16'h0001, 16'hFFFF, 16'h1000, 1,
          16'hABCD, 16'h0001, 16'hFFFF},
        '{MODE_LINEAR, 16'd256, 16'h0000, 16'hFFFF, 16'h8000, 16'h0800, 0, 0, 0, 0},
        '{MODE_LINEAR, 16'd0, 16'h5555, 16'hAAAA, 16'h0F0F, 16'hFFFF, 0, 0, 0, 0},
        '{MODE_LINEAR, 16'hFFFF, 16'h1111, 16'h2222, 16'h3333, 16'hFFFF, 1,
          16'h1111, 16'h2222, 16'h3333},
        '{MODE_LOG, 16'd256, 16'h0000, 16'hFFFF, 16'h0001, 16'h0400, 0, 0, 0, 0},
        '{MODE_LOG, 16'd256, 16'hFFFF, 16'h0000, 16'h1000, 16'h1000, 0, 0, 0, 0},
        '{MODE_LOG, 16'h1000, 16'h0300, 16'h7000, 16'h0040, 16'h0010, 0, 0, 0, 0},
        '{MODE_SNAP, 16'd256, 16'h0000, 16'hFFFF, 16'h7777, 16'h0000, 1,
          16'h0000, 16'hFFFF, 16'h7777},
        '{MODE_SNAP, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0001, 16'hFFFF, 1,
          16'hFFFF, 16'h0000, 16'h0001},
        '{MODE_OKLAB, 16'h0080, 16'h2000, 16'h3000, 16'h0800, 16'h3000, 0, 0, 0, 0},
        '{MODE_OKLAB, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h0001, 0, 0, 0, 0}
    };

    initial begin
        t_in_word    w;
        logic [1:0]  mode;
        logic [15:0] factor;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // A write to the spare index must leave both registers alone.
        write_reg(REG_SPARE, 16'($urandom));
        i_cfg_valid <= 1'b0;

        foreach (steps[n]) begin
            if (steps[n].mode != drive_mode || steps[n].factor != drive_factor)
                reconfigure(steps[n].mode, steps[n].factor);
            w = '{steps[n].r, steps[n].g, steps[n].b, steps[n].dt};
            send_word(w, steps[n].typed, '{steps[n].er, steps[n].eg, steps[n].eb});
        end

        for (int phase = 0; phase < 8; phase++) begin
            mode = 2'(phase);
            case (phase)
                0, 5:    factor = 16'd256;
                1:       factor = 16'd1;
                2:       factor = 16'hFFFF;
                3:       factor = 16'd0;
                default: factor = 16'($urandom);
            endcase
            reconfigure(mode, factor);
            no_gaps = (phase == 4);
            for (int k = 0; k < 48; k++) begin
                w.target_red   = pick_colour();
                w.target_green = pick_colour();
                w.target_blue  = pick_colour();
                w.delta_time   = ($urandom_range(3) == 0) ? 16'($urandom)
                                                          : 16'($urandom_range(16'h0400));
                send_word(w, 1'b0, '0);
                if (phase == 6 && k == 10) hold_req = 1'b1;
            end
            no_gaps = 1'b0;
        end
        i_in_valid <= 1'b0;

        while (colour_queue.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        $display("Sent %0d colour words and checked %0d results across all four blend modes,",
                 words_in, words_out);
        $display("with factors from zero to full scale and one long result-side hold-off.");
        if (errors == 0) begin
            $display("oklab_color_smoother: match");
        end else begin
            $display("oklab_color_smoother: mismatch");
        end
        $finish;
    end

endmodule
